### hw/rtl/upsc_pkg.sv
// Shared types and codes for the pixel replication upscaler.
`default_nettype none

package upsc_pkg;

    // Input beat operation codes
    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Byte lanes of a stored pixel
    localparam logic [1:0] LANE_BLUE  = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_RED   = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/upsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module upsc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pixel_replication_upscaler.sv
// Top level of the pixel replication upscaler: line buffer, counters, output stage.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_operation, i_blue, i_green, i_red
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_out_byte, o_row_end, o_image_end
//  cfg     | input     | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// One beat is taken per clock while o_in_ready is high. A result is held in the line buffer read
// register, then in the output register, from which it leaves.
// Reset is synchronous and clears all counters, mode and valid flags; the line buffer is
// not cleared. An output stall holds the output register and the read stage behind it;
// input keeps flowing as long as either stage has room.
`default_nettype none

module pixel_replication_upscaler #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_blue,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_red,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic      [7:0]  o_out_byte,
    output logic             o_row_end,
    output logic             o_image_end,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import upsc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int SW = $clog2(MAX_SCALE + 1);

    typedef struct packed {
        logic       status;
        logic       zero;
        logic [1:0] lane;
        logic       row_end;
        logic       image_end;
    } t_s1_meta;

    // Configuration
    logic [4:0]  r_scale;
    logic [10:0] r_src_width;
    logic [15:0] r_src_height;

    logic [CW-1:0] eff_w;
    logic [SW-1:0] eff_s;
    logic [15:0]   eff_h;
    logic [3:0]    wm_sm;
    logic [5:0]    row_mod3;
    logic [1:0]    pad;

    // Scan state
    logic          r_emitting,  n_emitting;
    logic [CW-1:0] r_fill_col,  n_fill_col;
    logic [CW-1:0] r_emit_col,  n_emit_col;
    logic [SW-1:0] r_across,    n_across;
    logic [1:0]    r_bip,       n_bip;
    logic [1:0]    r_pad_cnt,   n_pad_cnt;
    logic [SW-1:0] r_down,      n_down;
    logic [15:0]   r_src_row,   n_src_row;

    // Pipeline
    logic     r_s1_valid, n_s1_valid;
    t_s1_meta r_s1,       n_s1;
    logic     s1_adv;
    logic     accept;
    logic     has_result;
    logic     ram_we;
    logic     ram_re;
    logic [23:0] ram_rdata;
    logic [7:0]  lane_byte;

    // Temporaries of the step logic
    logic [CW-1:0] fill_inc;
    logic [CW-1:0] emit_next;
    logic [SW-1:0] across_inc;
    logic [SW-1:0] down_inc;
    logic [1:0]    lane;
    logic [1:0]    bip_inc;
    logic [2:0]    pad_inc;
    logic [16:0]   row_inc;
    logic          last;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= 5'd1;
            r_src_width  <= 11'd1;
            r_src_height <= 16'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_SCALE:  r_scale      <= pwdata[4:0];
                REG_WIDTH:  r_src_width  <= pwdata[10:0];
                REG_HEIGHT: r_src_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCALE:  prdata = {27'd0, r_scale};
            REG_WIDTH:  prdata = {21'd0, r_src_width};
            REG_HEIGHT: prdata = {16'd0, r_src_height};
            default:    prdata = 32'd0;
        endcase
    end

    // Clamped working values
    always_comb begin
        if (r_scale == 5'd0) begin
            eff_s = SW'(1);
        end else if (32'(r_scale) > 32'(MAX_SCALE)) begin
            eff_s = SW'(MAX_SCALE);
        end else begin
            eff_s = SW'(r_scale);
        end

        if (r_src_width == 11'd0) begin
            eff_w = CW'(1);
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_src_width);
        end

        eff_h = (r_src_height == 16'd0) ? 16'd1 : r_src_height;
    end

    // Row length mod 4 only depends on width and scale mod 4
    assign wm_sm    = eff_w[1:0] * eff_s[1:0];
    assign row_mod3 = 6'(wm_sm) * 6'd3;
    assign pad      = 2'd0 - row_mod3[1:0];

    // ---------------- handshake ----------------
    assign s1_adv     = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // ---------------- step logic ----------------
    always_comb begin
        n_emitting = r_emitting;
        n_fill_col = r_fill_col;
        n_emit_col = r_emit_col;
        n_across   = r_across;
        n_bip      = r_bip;
        n_pad_cnt  = r_pad_cnt;
        n_down     = r_down;
        n_src_row  = r_src_row;

        has_result = 1'b0;
        n_s1       = '{status: STATUS_OK, zero: 1'b1, lane: LANE_BLUE,
                       row_end: 1'b0, image_end: 1'b0};
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        last       = 1'b0;

        fill_inc   = r_fill_col + CW'(1);
        lane       = (r_bip > LANE_RED) ? LANE_RED : r_bip;
        bip_inc    = lane + 2'd1;
        across_inc = r_across + SW'(1);
        emit_next  = r_emit_col;
        pad_inc    = {1'b0, r_pad_cnt} + 3'd1;
        down_inc   = r_down + SW'(1);
        row_inc    = {1'b0, r_src_row} + 17'd1;

        if (accept) begin
            if (t_op'(i_operation) == OP_PUSH) begin
                if (r_emitting) begin
                    // pixel lost while the row is being sent out
                    has_result  = 1'b1;
                    n_s1.status = STATUS_DROP;
                end else begin
                    ram_we = 1'b1;
                    if (fill_inc >= eff_w) begin
                        n_fill_col = '0;
                        n_emitting = 1'b1;
                        n_emit_col = '0;
                        n_across   = '0;
                        n_bip      = '0;
                        n_pad_cnt  = '0;
                    end else begin
                        n_fill_col = fill_inc;
                    end
                end
            end else if (r_emitting) begin
                has_result = 1'b1;
                if (r_emit_col < eff_w) begin
                    ram_re    = 1'b1;
                    n_s1.zero = 1'b0;
                    n_s1.lane = lane;
                    if (bip_inc == 2'd3) begin
                        n_bip = '0;
                        if (across_inc >= eff_s) begin
                            n_across  = '0;
                            emit_next = r_emit_col + CW'(1);
                        end else begin
                            n_across = across_inc;
                        end
                    end else begin
                        n_bip = bip_inc;
                    end
                    n_emit_col = emit_next;
                    if (emit_next >= eff_w && pad == 2'd0) begin
                        last = 1'b1;
                    end
                end else begin
                    // padding zeros
                    n_pad_cnt = pad_inc[1:0];
                    if (pad_inc >= {1'b0, pad}) begin
                        last = 1'b1;
                    end
                end

                if (last) begin
                    n_s1.row_end = 1'b1;
                    n_emit_col   = '0;
                    n_across     = '0;
                    n_bip        = '0;
                    n_pad_cnt    = '0;
                    if (down_inc >= eff_s) begin
                        n_down     = '0;
                        n_emitting = 1'b0;
                        n_fill_col = '0;
                        if (row_inc >= {1'b0, eff_h}) begin
                            n_src_row      = '0;
                            n_s1.image_end = 1'b1;
                        end else begin
                            n_src_row = row_inc[15:0];
                        end
                    end else begin
                        n_down = down_inc;
                    end
                end
            end
        end
    end

    always_comb begin
        if (accept) begin
            n_s1_valid = has_result;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting <= 1'b0;
            r_fill_col <= '0;
            r_emit_col <= '0;
            r_across   <= '0;
            r_bip      <= '0;
            r_pad_cnt  <= '0;
            r_down     <= '0;
            r_src_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_emitting <= n_emitting;
            r_fill_col <= n_fill_col;
            r_emit_col <= n_emit_col;
            r_across   <= n_across;
            r_bip      <= n_bip;
            r_pad_cnt  <= n_pad_cnt;
            r_down     <= n_down;
            r_src_row  <= n_src_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- line buffer ----------------
    upsc_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill_col[AW-1:0]),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_re    (ram_re),
        .i_raddr (r_emit_col[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------- output register ----------------
    always_comb begin
        case (r_s1.lane)
            LANE_BLUE:  lane_byte = ram_rdata[7:0];
            LANE_GREEN: lane_byte = ram_rdata[15:8];
            default:    lane_byte = ram_rdata[23:16];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_adv) begin
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            o_status    <= r_s1.status;
            o_out_byte  <= r_s1.zero ? 8'h00 : lane_byte;
            o_row_end   <= r_s1.row_end;
            o_image_end <= r_s1.image_end;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/upsc_checker.sv
// Port-level checks for the pixel replication upscaler, bound to the top level.
`default_nettype none

module upsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_status,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_row_end,
    input wire logic       o_image_end
);

    import upsc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_status) && $stable(o_row_end) && $stable(o_image_end))
        else $error("result beat changed while stalled");

    // a drop report carries no byte and no row or image marks
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STATUS_DROP |->
            o_out_byte == 8'h00 && !o_row_end && !o_image_end)
        else $error("drop report with byte or end marks");

    // the last byte of the image also closes a row
    a_image_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_end |-> o_row_end)
        else $error("image end without row end");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind pixel_replication_upscaler upsc_checker u_upsc_checker (.*);

`default_nettype wire

### tb/tb_pixel_replication_upscaler.sv
// Testbench for the pixel replication upscaler: directed and random beats checked by a predictor.
`timescale 1ns / 100ps

module tb_pixel_replication_upscaler;
    import upsc_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_SCALE     = 16;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BEATS  = 400;
    localparam int TIMEOUT_NS    = 8_000_000;

    typedef struct packed {
        logic       status;
        logic [7:0] data;
        logic       row_end;
        logic       image_end;
    } t_out_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_operation = 1'b0;
    logic [7:0]  i_blue      = 8'h00;
    logic [7:0]  i_green     = 8'h00;
    logic [7:0]  i_red       = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_status;
    logic [7:0]  o_out_byte;
    logic        o_row_end;
    logic        o_image_end;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'h0;
    logic [31:0] pwdata      = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    pixel_replication_upscaler #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_SCALE(MAX_SCALE)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .i_blue(i_blue),
        .i_green(i_green),
        .i_red(i_red),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_out_byte(o_out_byte),
        .o_row_end(o_row_end),
        .o_image_end(o_image_end),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor state
    logic [23:0] line_store [MAX_WIDTH];
    logic        emitting;
    logic [10:0] fill_col;
    logic [10:0] emit_col;
    logic [4:0]  across_rep;
    logic [4:0]  down_rep;
    logic [1:0]  lane_pos;
    logic [2:0]  pad_cnt;
    logic [16:0] src_row;
    logic [4:0]  cfg_scale;
    logic [10:0] cfg_width;
    logic [15:0] cfg_height;
    int unsigned max_filled;    // store entries 0..max_filled-1 hold written pixels

    t_out_beat   owed_bytes [$];

    int unsigned beats_sent      = 0;
    int unsigned effective_beats = 0;
    int unsigned results_checked = 0;
    int unsigned drops_seen      = 0;
    int unsigned rows_seen       = 0;
    int unsigned images_seen     = 0;
    int unsigned reg_writes      = 0;
    int unsigned mismatches      = 0;

    int unsigned burst_left = 0;
    bit          gaps_on    = 1'b1;
    int unsigned sink_left  = 0;
    int unsigned sink_mode  = 0;
    t_out_beat   got_beat;
    t_out_beat   want_beat;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("pixel_replication_upscaler verification failed");
        $finish;
    end

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic string describe(t_out_beat ob);
        return $sformatf("status=%0d byte=%02h row_end=%0d image_end=%0d",
                         ob.status, ob.data, ob.row_end, ob.image_end);
    endfunction

    // Advance the upscaler state by one accepted beat and queue what it owes
    function automatic void upscale_predict(t_op op, logic [7:0] b, logic [7:0] g,
                                            logic [7:0] r);
        int unsigned w;
        int unsigned s;
        int unsigned h;
        int unsigned pad;
        logic [1:0]  lane;
        logic [7:0]  data;
        logic        row_done;
        logic        img_done;
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        s = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_SCALE) ? MAX_SCALE : cfg_scale;
        h = (cfg_height == 0) ? 1 : cfg_height;
        pad = (4 - (3 * w * s) % 4) % 4;
        data = 8'h00;
        row_done = 1'b0;
        img_done = 1'b0;

        if (op == OP_PUSH) begin
            effective_beats++;
            if (emitting) begin
                owed_bytes.push_back(t_out_beat'{STATUS_DROP, 8'h00, 1'b0, 1'b0});
                return;
            end
            if (fill_col < MAX_WIDTH) begin
                line_store[fill_col[9:0]] = {r, g, b};
                if (fill_col + 1 > max_filled) max_filled = fill_col + 1;
            end
            fill_col++;
            if (fill_col >= w) begin
                fill_col = '0;
                emitting = 1'b1;
                emit_col = '0;
                across_rep = '0;
                lane_pos = '0;
                pad_cnt = '0;
            end
            return;
        end

        if (!emitting) return;     // tick while filling is ignored
        effective_beats++;

        if (emit_col < w) begin
            lane = (lane_pos > LANE_RED) ? LANE_RED : lane_pos;
            data = line_store[emit_col[9:0]][8*lane +: 8];
            lane_pos = lane + 2'd1;
            if (lane_pos >= 2'd3) begin
                lane_pos = '0;
                across_rep++;
                if (across_rep >= s) begin
                    across_rep = '0;
                    emit_col++;
                end
            end
            if (emit_col >= w && pad == 0) row_done = 1'b1;
        end else begin
            pad_cnt++;
            if (pad_cnt >= pad) row_done = 1'b1;
        end

        if (row_done) begin
            emit_col = '0;
            across_rep = '0;
            lane_pos = '0;
            pad_cnt = '0;
            down_rep++;
            if (down_rep >= s) begin
                down_rep = '0;
                emitting = 1'b0;
                fill_col = '0;
                src_row++;
                if (src_row >= h) begin
                    src_row = '0;
                    img_done = 1'b1;
                end
            end
        end
        owed_bytes.push_back(t_out_beat'{STATUS_OK, data, row_done, img_done});
    endfunction

    // Output side: the stall pattern is redrawn whenever its random run length runs out
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(8, 60);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= $urandom_range(0, 1);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got_beat = t_out_beat'{o_status, o_out_byte, o_row_end, o_image_end};
            results_checked++;
            if (got_beat.status === STATUS_DROP) drops_seen++;
            if (got_beat.row_end === 1'b1) rows_seen++;
            if (got_beat.image_end === 1'b1) images_seen++;
            if (owed_bytes.size() == 0) begin
                note_mismatch({"result with nothing owed: ", describe(got_beat)});
            end else begin
                want_beat = owed_bytes.pop_front();
                if (got_beat !== want_beat) begin
                    note_mismatch({"expected ", describe(want_beat),
                                   " got ", describe(got_beat)});
                end
            end
        end
    end

    task automatic send_beat(input t_op op, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on && $urandom_range(0, 1)) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_blue      <= b;
        i_green     <= g;
        i_red       <= r;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        beats_sent++;
        upscale_predict(op, b, g, r);
    endtask

    // Hold input until every owed result is out, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (owed_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== want) begin
            note_mismatch($sformatf("register %0d reads %08h, expected %08h",
                                    idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        reg_writes++;
        case (idx)
            REG_SCALE:  cfg_scale  = value[4:0];
            REG_WIDTH:  cfg_width  = value[10:0];
            REG_HEIGHT: cfg_height = value[15:0];
            default: ;
        endcase
        read_reg(idx, value);
    endtask

    task automatic write_config(input int unsigned s, input int unsigned w,
                                input int unsigned h);
        write_reg(REG_SCALE, s);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Up to n ticks while output rows are going out; n < 0 runs to the end of the row group
    task automatic tick_burst(input int n);
        int sent;
        sent = 0;
        while (emitting && (n < 0 || sent < n)) begin
            send_beat(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
        end
    endtask

    // One source row in, all its output rows out, with optional noise and a
    // register change partway through the output
    task automatic stream_source_row(input int unsigned noise_pct, input int tweak_at);
        int ticks;
        int unsigned wmax;
        ticks = 0;
        while (!emitting) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_beat(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        while (emitting) begin
            if (ticks == tweak_at) begin
                drain_results();
                wmax = (max_filled < 12) ? max_filled : 12;
                case ($urandom_range(0, 2))
                    0: write_reg(REG_SCALE, $urandom_range(0, (cfg_width > 12) ? 1 : 4));
                    1: write_reg(REG_WIDTH, $urandom_range(0, wmax));
                    default: write_reg(REG_HEIGHT, $urandom_range(0, 4));
                endcase
            end
            if ($urandom_range(0, 99) < noise_pct) begin
                send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_beat(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            ticks++;
        end
    endtask

    task automatic test_reset_defaults();
        read_reg(REG_SCALE, 32'd1);
        read_reg(REG_WIDTH, 32'd1);
        read_reg(REG_HEIGHT, 32'd1);
        send_beat(OP_TICK, 8'h00, 8'h00, 8'h00);
        stream_source_row(0, -1);
        stream_source_row(0, -1);
        drain_results();
    endtask

    task automatic test_directed_beats();
        write_config(1, 2, 2);
        send_beat(OP_TICK, 8'hFF, 8'hFF, 8'hFF);      // ignored while filling
        send_beat(OP_PUSH, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_PUSH, 8'h00, 8'h00, 8'h00);
        send_beat(OP_PUSH, 8'h12, 8'h34, 8'h56);      // dropped, row is going out
        repeat (8) send_beat(OP_TICK, 8'h00, 8'h00, 8'h00);
        send_beat(OP_PUSH, 8'h5A, 8'hA5, 8'h3C);
        send_beat(OP_PUSH, 8'hC3, 8'h96, 8'h69);
        repeat (4) send_beat(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_PUSH, 8'hAA, 8'h55, 8'hF0);
        repeat (4) send_beat(OP_TICK, 8'h00, 8'h00, 8'h00);   // last one ends the image
        drain_results();
    endtask

    task automatic test_register_extremes();
        int unsigned sweep [3][4] = '{
            '{0, 0, 0, 1}, '{2, 3, 65535, 1}, '{3, 4, 3, 2}
        };
        for (int i = 0; i < 3; i++) begin
            drain_results();
            write_config(sweep[i][0], sweep[i][1], sweep[i][2]);
            repeat (sweep[i][3]) stream_source_row(0, -1);
        end

        // scale above the limit: one full output row at the clamped scale, then cut short
        drain_results();
        write_config(31, 1, 1);
        send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        tick_burst(48);
        drain_results();
        write_reg(REG_SCALE, 1);
        tick_burst(-1);

        // width above the limit: the row fills at the clamped width, then is cut short
        drain_results();
        write_config(1, 2047, 1);
        while (!emitting) begin
            send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        tick_burst(6);
        drain_results();
        write_reg(REG_WIDTH, 1);
        tick_burst(-1);
        drain_results();
    endtask

    task automatic test_midrow_changes();
        write_config(2, 6, 3);
        repeat (4) send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        drain_results();
        write_reg(REG_WIDTH, 3);          // fill is already past the new width
        send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        tick_burst(10);
        drain_results();
        write_reg(REG_SCALE, 5);
        tick_burst(20);
        drain_results();
        write_reg(REG_WIDTH, 1);
        tick_burst(7);
        drain_results();
        write_reg(REG_HEIGHT, 1);
        tick_burst(-1);

        // shrink the padding while it is being sent
        drain_results();
        write_config(1, 3, 2);
        repeat (3) send_beat(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        while (emitting && !(emit_col >= 3 && pad_cnt == 1)) begin
            send_beat(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        drain_results();
        write_reg(REG_SCALE, 4);
        tick_burst(-1);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned s;
        int unsigned w;
        int unsigned h;
        int          tweak;
        start = effective_beats;
        while (effective_beats - start < RANDOM_BEATS) begin
            drain_results();
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                w = $urandom_range(0, 3);
                s = $urandom_range(0, 5);
            end else begin
                w = $urandom_range(1, 12);
                s = $urandom_range(1, 4);
            end
            h = ($urandom_range(0, 29) == 0) ? 65535 : $urandom_range(0, 4);
            write_config(s, w, h);
            repeat ($urandom_range(1, 3)) begin
                tweak = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 40)) : -1;
                stream_source_row(5, tweak);
            end
        end
        drain_results();
    endtask

    initial begin
        emitting   = 1'b0;
        fill_col   = '0;
        emit_col   = '0;
        across_rep = '0;
        down_rep   = '0;
        lane_pos   = '0;
        pad_cnt    = '0;
        src_row    = '0;
        cfg_scale  = 5'd1;
        cfg_width  = 11'd1;
        cfg_height = 16'd1;
        max_filled = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_beats();
        test_register_extremes();
        test_midrow_changes();
        test_random_traffic();

        drain_results();
        $display("Covered %0d beats (%0d not ignored), %0d results checked, %0d drops flagged.",
                 beats_sent, effective_beats, results_checked, drops_seen);
        $display("Saw %0d output rows and %0d image ends over %0d register writes; %0d mismatches.",
                 rows_seen, images_seen, reg_writes, mismatches);
        if (mismatches == 0 && owed_bytes.size() == 0) begin
            $display("pixel_replication_upscaler verification clean");
        end else begin
            $display("pixel_replication_upscaler verification failed");
        end
        $finish;
    end

endmodule
